>>> hdl/grc_pkg.sv
`timescale 1ns / 1ps

package grc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 22;
    localparam int CELL_W    = 6;
    localparam int DIR_W     = 19;
    localparam int LEN_W     = 32;
    localparam int DIST_W    = 32;
    localparam int HEIGHT_W  = 16;
    localparam int ROW_W     = 9;
    localparam int IDX_W     = 2;

    localparam logic [IDX_W-1:0] REG_PLAYER_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_PLAYER_Y = 2'd1;

    typedef enum logic
    {
        KIND_WRITE = 1'b0,
        KIND_CAST  = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        FACE_WEST  = 2'd0,
        FACE_EAST  = 2'd1,
        FACE_SOUTH = 2'd2,
        FACE_NORTH = 2'd3
    } face_t;

    typedef enum logic [3:0]
    {
        BK_CLEAR,
        BK_IDLE,
        BK_MUL_X,
        BK_MUL_Y,
        BK_SET_Y,
        BK_STEP,
        BK_CHECK,
        BK_HIT,
        BK_MUL_F,
        BK_FRAC,
        BK_DIV,
        BK_DONE
    } back_state_t;

    typedef struct packed
    {
        kind_t                     kind;
        logic [CELL_W-1:0]         cell_x;
        logic [CELL_W-1:0]         cell_y;
        logic                      cell_is_wall;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic [LEN_W-1:0]          step_len_x;
        logic [LEN_W-1:0]          step_len_y;
    } item_t;

    typedef struct packed
    {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

>>> hdl/grc_front.sv
`timescale 1ns / 1ps

module grc_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               action,
    input  logic [grc_pkg::CELL_W-1:0]         cell_x,
    input  logic [grc_pkg::CELL_W-1:0]         cell_y,
    input  logic                               cell_is_wall,
    input  logic signed [grc_pkg::DIR_W-1:0]   dir_x,
    input  logic signed [grc_pkg::DIR_W-1:0]   dir_y,
    input  logic [grc_pkg::LEN_W-1:0]          step_len_x,
    input  logic [grc_pkg::LEN_W-1:0]          step_len_y,
    input  logic                               clearing,
    input  logic                               pop,
    output logic                               busy,
    output grc_pkg::queue_head_t               head
);

    grc_pkg::item_t fifo_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    grc_pkg::item_t new_item;

    assign busy = clearing || (count_reg == 2'd2);
    assign push = start && !busy;

    always_comb
    begin
        new_item.kind         = action ? grc_pkg::KIND_CAST : grc_pkg::KIND_WRITE;
        new_item.cell_x       = cell_x;
        new_item.cell_y       = cell_y;
        new_item.cell_is_wall = cell_is_wall;
        new_item.dir_x        = dir_x;
        new_item.dir_y        = dir_y;
        new_item.step_len_x   = step_len_x;
        new_item.step_len_y   = step_len_y;
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = fifo_reg[rd_ptr_reg];

endmodule

>>> hdl/grc_back.sv
`timescale 1ns / 1ps

module grc_back
#(
    parameter int MAP_WIDTH     = 64,
    parameter int MAP_HEIGHT    = 64,
    parameter int SCREEN_HEIGHT = 480
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  grc_pkg::queue_head_t               head,
    input  logic [grc_pkg::POS_W-1:0]          player_x,
    input  logic [grc_pkg::POS_W-1:0]          player_y,
    output logic                               pop,
    output logic                               clearing,
    output logic                               done,
    output logic [grc_pkg::DIST_W-1:0]         perp_dist,
    output logic                               hit_side,
    output logic [1:0]                         face,
    output logic [grc_pkg::CELL_W-1:0]         hit_x,
    output logic [grc_pkg::CELL_W-1:0]         hit_y,
    output logic [grc_pkg::HEIGHT_W-1:0]       column_height,
    output logic [grc_pkg::ROW_W-1:0]          draw_top,
    output logic [grc_pkg::ROW_W-1:0]          draw_bottom,
    output logic [grc_pkg::HEIGHT_W-1:0]       hit_frac
);

    localparam int FB     = grc_pkg::FRAC_BITS;
    localparam int DW     = grc_pkg::DIR_W;
    localparam int LW     = grc_pkg::LEN_W;
    localparam int XW     = $clog2(MAP_WIDTH + 64) + 1;
    localparam int YW     = $clog2(MAP_HEIGHT + 64) + 1;
    localparam int DEPTH  = MAP_WIDTH * MAP_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SD_W   = LW + $clog2(MAP_WIDTH + MAP_HEIGHT + 2) + 1;
    localparam int NUM_W  = $clog2(SCREEN_HEIGHT + 1) + FB;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int RW     = $clog2(SCREEN_HEIGHT + 65536) + 1;
    localparam int PW     = LW + DW;
    localparam logic [NUM_W-1:0]  NUMER = NUM_W'(SCREEN_HEIGHT) << FB;
    localparam logic [RW-1:0]     HALF_SCREEN = RW'(SCREEN_HEIGHT / 2);
    localparam logic [RW-1:0]     FULL_SCREEN = RW'(SCREEN_HEIGHT);

    grc_pkg::back_state_t state_reg;
    grc_pkg::back_state_t state_next;

    logic                 mem [DEPTH];
    logic                 mem_q_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic                 mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;

    logic [ADDR_W-1:0]    clr_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic signed [DW-1:0] dx_reg;
    logic signed [DW-1:0] dy_reg;
    logic [LW-1:0]        lx_reg;
    logic [LW-1:0]        ly_reg;
    logic signed [XW-1:0] mx_reg;
    logic signed [YW-1:0] my_reg;
    logic [SD_W-1:0]      sx_reg;
    logic [SD_W-1:0]      sy_reg;
    logic [SD_W-1:0]      prev_reg;
    logic                 side_reg;
    logic                 oob_reg;

    logic [LW-1:0]        mul_a_reg;
    logic [DW-1:0]        mul_b_reg;
    logic [PW-1:0]        mul_p_reg;

    logic [grc_pkg::DIST_W-1:0]   dist_reg;
    logic [grc_pkg::HEIGHT_W-1:0] frac_reg;
    logic [grc_pkg::DIST_W-1:0]   rem_reg;
    logic [NUM_W-1:0]             quo_reg;
    logic [NUM_W-1:0]             num_reg;

    logic                 done_reg;
    logic [grc_pkg::DIST_W-1:0]   perp_dist_reg;
    logic                 hit_side_reg;
    logic [1:0]           face_reg;
    logic [grc_pkg::CELL_W-1:0]   hit_x_reg;
    logic [grc_pkg::CELL_W-1:0]   hit_y_reg;
    logic [grc_pkg::HEIGHT_W-1:0] height_reg;
    logic [grc_pkg::ROW_W-1:0]    top_reg;
    logic [grc_pkg::ROW_W-1:0]    bottom_reg;

    logic                 wr_in_map;
    logic                 x_first;
    logic signed [XW-1:0] mx_step;
    logic signed [YW-1:0] my_step;
    logic signed [XW-1:0] nmx;
    logic signed [YW-1:0] nmy;
    logic                 oob_n;
    logic [grc_pkg::DIST_W-1:0]   dist_sat;
    logic                 use_dx;
    logic signed [DW-1:0] frac_dir;
    logic [DW-1:0]        frac_dir_abs;
    logic [LW-1:0]        frac_total;
    logic [LW-1:0]        prod_lo;
    logic [grc_pkg::DIST_W:0]     rem_sh;
    logic                 rem_ge;
    logic [grc_pkg::HEIGHT_W-1:0] height;
    logic [RW-1:0]        half;
    logic [RW-1:0]        bot_sum;
    logic [RW-1:0]        top_val;
    logic [RW-1:0]        bot_val;
    logic [DW-1:0]        bx_init;
    logic [DW-1:0]        by_init;
    logic [1:0]           face_val;

    // Writes to cells beyond the map are dropped.
    assign wr_in_map = (int'(head.item.cell_x) < MAP_WIDTH)
                    && (int'(head.item.cell_y) < MAP_HEIGHT);

    // Distance from the player to the first grid line on each axis, in cell units.
    assign bx_init = head.item.dir_x[DW-1] ? DW'(player_x[FB-1:0])
                   : (DW'(1) << FB) - DW'(player_x[FB-1:0]);
    assign by_init = head.item.dir_y[DW-1] ? DW'(player_y[FB-1:0])
                   : (DW'(1) << FB) - DW'(player_y[FB-1:0]);

    // On a tie the y axis steps.
    assign x_first = sx_reg < sy_reg;
    assign mx_step = dx_reg[DW-1] ? mx_reg - XW'(1) : mx_reg + XW'(1);
    assign my_step = dy_reg[DW-1] ? my_reg - YW'(1) : my_reg + YW'(1);
    assign nmx     = x_first ? mx_step : mx_reg;
    assign nmy     = x_first ? my_reg : my_step;
    assign oob_n   = nmx[XW-1] || nmy[YW-1]
                  || (nmx >= signed'(XW'(MAP_WIDTH)))
                  || (nmy >= signed'(YW'(MAP_HEIGHT)));

    assign dist_sat = (|prev_reg[SD_W-1:grc_pkg::DIST_W]) ? '1
                    : prev_reg[grc_pkg::DIST_W-1:0];

    assign use_dx       = side_reg;
    assign frac_dir     = use_dx ? dx_reg : dy_reg;
    assign frac_dir_abs = frac_dir[DW-1] ? DW'(~frac_dir + DW'(1)) : DW'(frac_dir);

    // Only the low word of position plus distance times direction reaches the fraction.
    assign prod_lo    = mul_p_reg[LW-1:0];
    assign frac_total = {(use_dx ? player_x[FB-1:0] : player_y[FB-1:0]), {(LW - FB){1'b0}}}
                      + (frac_dir[DW-1] ? (~prod_lo + LW'(1)) : prod_lo);

    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge = rem_sh >= {1'b0, dist_reg};

    assign height  = ((dist_reg == '0) || (|quo_reg[NUM_W-1:grc_pkg::HEIGHT_W])) ? '1
                   : quo_reg[grc_pkg::HEIGHT_W-1:0];
    assign half    = RW'(height >> 1);
    assign bot_sum = HALF_SCREEN + half;
    assign top_val = (half > HALF_SCREEN) ? '0 : HALF_SCREEN - half;
    assign bot_val = (bot_sum >= FULL_SCREEN) ? FULL_SCREEN : bot_sum;

    always_comb
    begin
        if (side_reg)
        begin
            face_val = (!dy_reg[DW-1] && (dy_reg != '0)) ? grc_pkg::FACE_SOUTH
                                                         : grc_pkg::FACE_NORTH;
        end
        else
        begin
            face_val = dx_reg[DW-1] ? grc_pkg::FACE_WEST : grc_pkg::FACE_EAST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= grc_pkg::BK_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = clr_reg;
        mem_wdata  = 1'b0;
        mem_raddr  = ADDR_W'(nmy) * ADDR_W'(MAP_WIDTH) + ADDR_W'(nmx);
        unique case (state_reg)
            grc_pkg::BK_CLEAR:
            begin
                mem_we = 1'b1;
                if (int'(clr_reg) == DEPTH - 1)
                begin
                    state_next = grc_pkg::BK_IDLE;
                end
            end
            grc_pkg::BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.item.kind == grc_pkg::KIND_CAST)
                    begin
                        state_next = grc_pkg::BK_MUL_X;
                    end
                    else
                    begin
                        mem_we    = wr_in_map;
                        mem_waddr = ADDR_W'(head.item.cell_y) * ADDR_W'(MAP_WIDTH)
                                  + ADDR_W'(head.item.cell_x);
                        mem_wdata = head.item.cell_is_wall;
                    end
                end
            end
            grc_pkg::BK_MUL_X: state_next = grc_pkg::BK_MUL_Y;
            grc_pkg::BK_MUL_Y: state_next = grc_pkg::BK_SET_Y;
            grc_pkg::BK_SET_Y: state_next = grc_pkg::BK_STEP;
            grc_pkg::BK_STEP:  state_next = grc_pkg::BK_CHECK;
            grc_pkg::BK_CHECK:
            begin
                // Leaving the map ends every walk, so no step limit is needed.
                state_next = (oob_reg || mem_q_reg) ? grc_pkg::BK_HIT : grc_pkg::BK_STEP;
            end
            grc_pkg::BK_HIT:   state_next = grc_pkg::BK_MUL_F;
            grc_pkg::BK_MUL_F: state_next = grc_pkg::BK_FRAC;
            grc_pkg::BK_FRAC:  state_next = grc_pkg::BK_DIV;
            grc_pkg::BK_DIV:
            begin
                if (int'(cnt_reg) == NUM_W - 1)
                begin
                    state_next = grc_pkg::BK_DONE;
                end
            end
            grc_pkg::BK_DONE:  state_next = grc_pkg::BK_IDLE;
            default:           state_next = grc_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == grc_pkg::BK_DONE);
            if (state_reg == grc_pkg::BK_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (state_reg == grc_pkg::BK_DIV)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= PW'(mul_a_reg) * PW'(mul_b_reg);
        unique case (state_reg)
            grc_pkg::BK_IDLE:
            begin
                dx_reg    <= head.item.dir_x;
                dy_reg    <= head.item.dir_y;
                lx_reg    <= head.item.step_len_x;
                ly_reg    <= head.item.step_len_y;
                mul_a_reg <= head.item.step_len_x;
                mul_b_reg <= bx_init;
                mx_reg    <= XW'(player_x[grc_pkg::POS_W-1:FB]);
                my_reg    <= YW'(player_y[grc_pkg::POS_W-1:FB]);
                prev_reg  <= '0;
                side_reg  <= 1'b0;
                // The y operands are set up while the x product forms.
                sy_reg    <= SD_W'(by_init);
            end
            grc_pkg::BK_MUL_X:
            begin
                mul_a_reg <= ly_reg;
                mul_b_reg <= DW'(sy_reg);
            end
            grc_pkg::BK_MUL_Y:
            begin
                sx_reg <= SD_W'(mul_p_reg >> FB);
            end
            grc_pkg::BK_SET_Y:
            begin
                sy_reg <= SD_W'(mul_p_reg >> FB);
            end
            grc_pkg::BK_STEP:
            begin
                if (x_first)
                begin
                    prev_reg <= sx_reg;
                    sx_reg   <= sx_reg + SD_W'(lx_reg);
                    side_reg <= 1'b0;
                end
                else
                begin
                    prev_reg <= sy_reg;
                    sy_reg   <= sy_reg + SD_W'(ly_reg);
                    side_reg <= 1'b1;
                end
                mx_reg  <= nmx;
                my_reg  <= nmy;
                oob_reg <= oob_n;
            end
            grc_pkg::BK_HIT:
            begin
                dist_reg  <= dist_sat;
                mul_a_reg <= dist_sat;
                mul_b_reg <= frac_dir_abs;
                rem_reg   <= '0;
                quo_reg   <= '0;
                num_reg   <= NUMER;
            end
            grc_pkg::BK_FRAC:
            begin
                frac_reg <= frac_total[LW-1:FB];
            end
            grc_pkg::BK_DIV:
            begin
                rem_reg <= rem_ge ? grc_pkg::DIST_W'(rem_sh - {1'b0, dist_reg})
                                  : grc_pkg::DIST_W'(rem_sh);
                quo_reg <= {quo_reg[NUM_W-2:0], rem_ge};
                num_reg <= num_reg << 1;
            end
            grc_pkg::BK_DONE:
            begin
                perp_dist_reg <= dist_reg;
                hit_side_reg  <= side_reg;
                face_reg      <= face_val;
                hit_x_reg     <= grc_pkg::CELL_W'(mx_reg);
                hit_y_reg     <= grc_pkg::CELL_W'(my_reg);
                height_reg    <= height;
                top_reg       <= grc_pkg::ROW_W'(top_val);
                bottom_reg    <= grc_pkg::ROW_W'(bot_val);
            end
            default:
            begin
            end
        endcase
    end

    assign clearing      = (state_reg == grc_pkg::BK_CLEAR);
    assign done          = done_reg;
    assign perp_dist     = perp_dist_reg;
    assign hit_side      = hit_side_reg;
    assign face          = face_reg;
    assign hit_x         = hit_x_reg;
    assign hit_y         = hit_y_reg;
    assign column_height = height_reg;
    assign draw_top      = top_reg;
    assign draw_bottom   = bottom_reg;
    assign hit_frac      = frac_reg;

endmodule

>>> hdl/grid_raycast_column_core.sv
`timescale 1ns / 1ps

// Channel    Transfer when              Payload
// item in    start && !busy             action, cell_x, cell_y, cell_is_wall,
//                                       dir_x, dir_y, step_len_x, step_len_y
// config     cfg_valid && cfg_ready     cfg_index, cfg_data
// result     done (one cycle)           perp_dist, hit_side, face, hit_x, hit_y,
//                                       column_height, draw_top, draw_bottom, hit_frac
//
// A map write is done in the back end's IDLE state as it is popped. A cast runs setup
// states MUL_X, MUL_Y and SET_Y, then STEP and CHECK per DDA step (the map memory read
// is registered), HIT, MUL_F and FRAC for the hit, the restoring height divider in DIV
// and DONE to load the result. After reset the back end clears the map with busy high.
// A two-entry queue sits between front and back; busy rises when it is full.
// The result receiver cannot stall; each result is valid only in its done cycle.
module grid_raycast_column_core
#(
    parameter int MAP_WIDTH     = 64,
    parameter int MAP_HEIGHT    = 64,
    parameter int SCREEN_HEIGHT = 480
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               action,
    input  logic [grc_pkg::CELL_W-1:0]         cell_x,
    input  logic [grc_pkg::CELL_W-1:0]         cell_y,
    input  logic                               cell_is_wall,
    input  logic signed [grc_pkg::DIR_W-1:0]   dir_x,
    input  logic signed [grc_pkg::DIR_W-1:0]   dir_y,
    input  logic [grc_pkg::LEN_W-1:0]          step_len_x,
    input  logic [grc_pkg::LEN_W-1:0]          step_len_y,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [grc_pkg::IDX_W-1:0]          cfg_index,
    input  logic [grc_pkg::POS_W-1:0]          cfg_data,
    output logic                               done,
    output logic [grc_pkg::DIST_W-1:0]         perp_dist,
    output logic                               hit_side,
    output logic [1:0]                         face,
    output logic [grc_pkg::CELL_W-1:0]         hit_x,
    output logic [grc_pkg::CELL_W-1:0]         hit_y,
    output logic [grc_pkg::HEIGHT_W-1:0]       column_height,
    output logic [grc_pkg::ROW_W-1:0]          draw_top,
    output logic [grc_pkg::ROW_W-1:0]          draw_bottom,
    output logic [grc_pkg::HEIGHT_W-1:0]       hit_frac
);

    logic [grc_pkg::POS_W-1:0] player_x_reg;
    logic [grc_pkg::POS_W-1:0] player_y_reg;
    grc_pkg::queue_head_t      head;
    logic                      pop;
    logic                      clearing;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_x_reg <= '0;
            player_y_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == grc_pkg::REG_PLAYER_X)
            begin
                player_x_reg <= cfg_data;
            end
            else if (cfg_index == grc_pkg::REG_PLAYER_Y)
            begin
                player_y_reg <= cfg_data;
            end
        end
    end

    grc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .action       (action),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .cell_is_wall (cell_is_wall),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .step_len_x   (step_len_x),
        .step_len_y   (step_len_y),
        .clearing     (clearing),
        .pop          (pop),
        .busy         (busy),
        .head         (head)
    );

    grc_back
    #(
        .MAP_WIDTH     (MAP_WIDTH),
        .MAP_HEIGHT    (MAP_HEIGHT),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .player_x      (player_x_reg),
        .player_y      (player_y_reg),
        .pop           (pop),
        .clearing      (clearing),
        .done          (done),
        .perp_dist     (perp_dist),
        .hit_side      (hit_side),
        .face          (face),
        .hit_x         (hit_x),
        .hit_y         (hit_y),
        .column_height (column_height),
        .draw_top      (draw_top),
        .draw_bottom   (draw_bottom),
        .hit_frac      (hit_frac)
    );

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_zero_dist_height: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (perp_dist == '0)) |-> (column_height == '1))
        else $error("zero distance without saturated height");

    a_face_side: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hit_side == face[1]))
        else $error("face does not match hit side");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");
`endif

endmodule
